// ===== src/h2dd_pkg.sv =====
// Shared types and constants for the HTTP/2 DATA frame depadder.
// No dependencies; imported by h2dd_core and http2_data_frame_depadder.
`timescale 1ns / 1ps
`default_nettype none

package h2dd_pkg;

    // Frame length bits actually used, and width of the receive counter.
    localparam int LENGTH_BITS = 24;
    localparam int COUNT_BITS  = 32;

    // Item kind carried on func.
    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_BYTE   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_PROTO  = 2'd1,
        STATUS_STRAY  = 2'd2
    } status_t;

    typedef struct packed {
        logic        func;
        logic [23:0] frame_length;
        logic        padded;
        logic        end_stream;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        frame_end;
        logic        stream_end;
        status_t     status;
        logic [31:0] bytes_credited;
    } result_t;

endpackage

`default_nettype wire

// ===== src/h2dd_core.sv =====
// Frame tracking state and combinational per-item update logic, registered on step.
// Depends on h2dd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h2dd_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire h2dd_pkg::item_t  item,
    output h2dd_pkg::result_t     result
);
    import h2dd_pkg::*;

    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]             pad_length_reg, pad_length_next;
    logic                   await_pad_reg, await_pad_next;
    logic                   ends_stream_reg, ends_stream_next;
    logic                   in_frame_reg, in_frame_next;
    logic                   error_reg, error_next;
    logic [COUNT_BITS-1:0]  total_reg, total_next;

    logic [LENGTH_BITS-1:0] flen;
    logic [LENGTH_BITS-1:0] byte_ext;
    logic [LENGTH_BITS-1:0] pad_ext;
    logic [COUNT_BITS+31:0] total_wide;

    assign flen       = item.frame_length[LENGTH_BITS-1:0];
    assign byte_ext   = LENGTH_BITS'(item.data_byte);
    assign pad_ext    = LENGTH_BITS'(pad_length_reg);
    assign total_wide = {32'd0, total_next};

    always_comb
    begin
        bytes_left_next  = bytes_left_reg;
        pad_length_next  = pad_length_reg;
        await_pad_next   = await_pad_reg;
        ends_stream_next = ends_stream_reg;
        in_frame_next    = in_frame_reg;
        error_next       = error_reg;
        total_next       = total_reg;

        result.out_byte   = 8'd0;
        result.out_valid  = 1'b0;
        result.frame_end  = 1'b0;
        result.stream_end = 1'b0;
        result.status     = STATUS_OK;

        if (error_reg)
        begin
            result.status = STATUS_PROTO;
        end
        else if (item.func == FUNC_HEADER)
        begin
            // New header; an open frame is dropped silently.
            bytes_left_next  = flen;
            pad_length_next  = 8'd0;
            await_pad_next   = item.padded;
            ends_stream_next = item.end_stream;
            in_frame_next    = 1'b1;
            if (flen == '0)
            begin
                in_frame_next = 1'b0;
                if (item.padded)
                begin
                    // no room for the pad length byte
                    await_pad_next = 1'b0;
                    error_next     = 1'b1;
                    result.status  = STATUS_PROTO;
                end
                else
                begin
                    result.frame_end  = 1'b1;
                    result.stream_end = item.end_stream;
                end
            end
        end
        else if (!in_frame_reg)
        begin
            result.status = STATUS_STRAY;
        end
        else if (await_pad_reg)
        begin
            if (byte_ext >= bytes_left_reg)
            begin
                error_next     = 1'b1;
                in_frame_next  = 1'b0;
                await_pad_next = 1'b0;
                result.status  = STATUS_PROTO;
            end
            else
            begin
                pad_length_next = item.data_byte;
                await_pad_next  = 1'b0;
                bytes_left_next = bytes_left_reg - LENGTH_BITS'(1);
                total_next      = total_reg + COUNT_BITS'(1);
            end
        end
        else
        begin
            // trailing pad bytes are the last pad_length bytes
            if (bytes_left_reg > pad_ext)
            begin
                result.out_valid = 1'b1;
                result.out_byte  = item.data_byte;
            end
            bytes_left_next = bytes_left_reg - LENGTH_BITS'(1);
            total_next      = total_reg + COUNT_BITS'(1);
        end

        if (!error_next && item.func == FUNC_BYTE && in_frame_next && !await_pad_next
            && bytes_left_next == '0)
        begin
            in_frame_next     = 1'b0;
            pad_length_next   = 8'd0;
            result.frame_end  = 1'b1;
            result.stream_end = ends_stream_next;
        end

        result.bytes_credited = total_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= '0;
            pad_length_reg  <= 8'd0;
            await_pad_reg   <= 1'b0;
            ends_stream_reg <= 1'b0;
            in_frame_reg    <= 1'b0;
            error_reg       <= 1'b0;
            total_reg       <= '0;
        end
        else if (step)
        begin
            bytes_left_reg  <= bytes_left_next;
            pad_length_reg  <= pad_length_next;
            await_pad_reg   <= await_pad_next;
            ends_stream_reg <= ends_stream_next;
            in_frame_reg    <= in_frame_next;
            error_reg       <= error_next;
            total_reg       <= total_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/http2_data_frame_depadder.sv =====
// HTTP/2 DATA frame depadder top level: input register, core, result register.
// Depends on h2dd_pkg and h2dd_core.
`timescale 1ns / 1ps
`default_nettype none

// Removes padding from HTTP/2 DATA frame payloads one byte per beat. A header
// beat (func 0) opens a frame with its length and flags; on a padded frame the
// first payload byte is the pad length, and the trailing pad bytes are dropped
// (out_valid low) while data bytes pass through. Every beat yields exactly one
// result beat carrying status, frame/stream end marks and the wrapping receive
// byte count. A bad pad length, or a padded frame of length zero, is a sticky
// protocol error cleared only by reset. Throughput is one beat per clock while
// results are taken. Beats pass the input register, then the result register,
// with all bookkeeping (a compare and a decrement of the remaining length) between.
module http2_data_frame_depadder (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [23:0] frame_length,
    input  wire logic        padded,
    input  wire logic        end_stream,
    input  wire logic [7:0]  data_byte,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic             frame_end,
    output logic             stream_end,
    output logic [1:0]       status,
    output logic [31:0]      bytes_credited
);
    import h2dd_pkg::*;

    // Input register: holds one accepted beat until the core consumes it.
    item_t   in_item_reg;
    logic    in_full_reg, in_full_next;

    // Result register: holds one finished beat until downstream takes it.
    result_t result_reg;
    logic    result_valid_reg, result_valid_next;

    result_t core_result;
    logic    step;
    logic    in_take;

    // Core consumes the held beat whenever the result slot is free or draining.
    assign step     = in_full_reg && (!result_valid_reg || result_ready);
    assign in_ready = !in_full_reg || step;
    assign in_take  = in_valid && in_ready;

    h2dd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (step)
        begin
            in_full_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (step)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg      <= in_full_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.func         <= func;
            in_item_reg.frame_length <= frame_length;
            in_item_reg.padded       <= padded;
            in_item_reg.end_stream   <= end_stream;
            in_item_reg.data_byte    <= data_byte;
        end
        if (step)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid   = result_valid_reg;
    assign out_byte       = result_reg.out_byte;
    assign out_valid      = result_reg.out_valid;
    assign frame_end      = result_reg.frame_end;
    assign stream_end     = result_reg.stream_end;
    assign status         = result_reg.status;
    assign bytes_credited = result_reg.bytes_credited;

`ifndef SYNTH
    // A passed data byte never comes with an error or stray status.
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_valid |-> status == STATUS_OK)
        else $error("data byte passed with non-ok status");

    // Frame end only on a clean beat, and stream end only with frame end.
    a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (frame_end || stream_end) |-> frame_end && status == STATUS_OK)
        else $error("bad frame or stream end marking");

    // Input side only stalls when a beat is held and the result slot is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_full_reg && result_valid && !result_ready)
        else $error("input stalled without downstream backpressure");

    // A consumed beat always shows up in the result register next cycle.
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> result_valid)
        else $error("consumed beat produced no result");
`endif

endmodule

`default_nettype wire
